// ===== design/fvdds_pkg.sv =====
// Package for the four-voice DDS tone mixer: item structs, sizing constants,
// and the sine and note tuning-word ROM tables built at elaboration.
// No dependencies.
`default_nettype none

package fvdds_pkg;

	localparam int VOICES_DEF            = 4;
	localparam int PHASE_INDEX_SHIFT_DEF = 24;
	localparam int TICKS_PER_MS_DEF      = 40;

	localparam int INPUT_NOTES   = 4;
	localparam int MIX_SHIFT     = 2;
	localparam int PHASE_W       = 32;
	localparam int NOTE_W        = 7;
	localparam int MS_W          = 16;
	localparam int PRESCALE_W    = 6;
	localparam int SAMPLE_W      = 8;
	localparam int SINE_DEPTH    = 256;
	localparam int NOTE_DEPTH    = 128;
	localparam logic [63:0] CLOCK_CENTI_HZ = 64'd4000000;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [NOTE_W-1:0] note_a;
		logic [NOTE_W-1:0] note_b;
		logic [NOTE_W-1:0] note_c;
		logic [NOTE_W-1:0] note_d;
		logic [MS_W-1:0]   event_ms;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                event_done;
	} out_item_t;

	typedef logic [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];
	typedef logic [PHASE_W-1:0]  note_rom_t [NOTE_DEPTH];

	localparam logic [6:0] QUARTER_WAVE [65] = '{
		7'd0, 7'd3, 7'd6, 7'd9, 7'd12, 7'd16, 7'd19, 7'd22,
		7'd25, 7'd28, 7'd31, 7'd34, 7'd37, 7'd40, 7'd43, 7'd46,
		7'd49, 7'd51, 7'd54, 7'd57, 7'd60, 7'd63, 7'd65, 7'd68,
		7'd71, 7'd73, 7'd76, 7'd78, 7'd81, 7'd83, 7'd85, 7'd88,
		7'd90, 7'd92, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd104,
		7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
		7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
		7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
		7'd127
	};

	// note frequencies in hundredths of a hertz; entries 0..7 are silent
	localparam logic [19:0] FREQ_CENTI_HZ [NOTE_DEPTH] = '{
		20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
		20'd818, 20'd866, 20'd918, 20'd972,
		20'd1030, 20'd1091, 20'd1156, 20'd1225, 20'd1298, 20'd1375, 20'd1457, 20'd1543,
		20'd1635, 20'd1732, 20'd1835, 20'd1945, 20'd2060, 20'd2183, 20'd2312, 20'd2450,
		20'd2596, 20'd2750, 20'd2914, 20'd3087, 20'd3270, 20'd3465, 20'd3671, 20'd3889,
		20'd4120, 20'd4365, 20'd4625, 20'd4900, 20'd5191, 20'd5500, 20'd5827, 20'd6174,
		20'd6541, 20'd6930, 20'd7342, 20'd7778, 20'd8241, 20'd8731, 20'd9250, 20'd9800,
		20'd10383, 20'd11000, 20'd11654, 20'd12347, 20'd13081, 20'd13859, 20'd14683,
		20'd15556, 20'd16481, 20'd17461, 20'd18500, 20'd19600, 20'd20765, 20'd22000,
		20'd23308, 20'd24694, 20'd26163, 20'd27718, 20'd29366, 20'd31113, 20'd32963,
		20'd34923, 20'd36999, 20'd39200, 20'd41530, 20'd44000, 20'd46616, 20'd49388,
		20'd52325, 20'd55437, 20'd58733, 20'd62225, 20'd65925, 20'd69846, 20'd73999,
		20'd78399, 20'd83061, 20'd88000, 20'd93233, 20'd98777, 20'd104650, 20'd110873,
		20'd117466, 20'd124451, 20'd131851, 20'd139691, 20'd147998, 20'd156798,
		20'd166122, 20'd176000, 20'd186466, 20'd197553, 20'd209300, 20'd221746,
		20'd234932, 20'd248902, 20'd263702, 20'd279383, 20'd295996, 20'd313596,
		20'd332244, 20'd352000, 20'd372931, 20'd395107, 20'd418601, 20'd443492,
		20'd469864, 20'd497803, 20'd527404, 20'd558765, 20'd591991, 20'd627193,
		20'd664488, 20'd704000, 20'd745862, 20'd790213
	};

	// full sine wave from the quarter table, offset 128
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t  rom;
		logic [1:0] quad;
		logic [6:0] k;
		logic [6:0] mag;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			quad = 2'(i >> 6);
			k    = 7'(i & 63);
			mag  = quad[0] ? QUARTER_WAVE[7'd64 - k] : QUARTER_WAVE[k];
			rom[i] = quad[1] ? (8'd128 - 8'(mag)) : (8'd128 + 8'(mag));
		end
		return rom;
	endfunction

	// floor(2^32 * f / 40 kHz), f in centi-hertz
	function automatic note_rom_t build_note_rom();
		note_rom_t   rom;
		logic [63:0] num;
		for (int i = 0; i < NOTE_DEPTH; i++) begin
			num    = 64'(FREQ_CENTI_HZ[i]) << 32;
			rom[i] = 32'(num / CLOCK_CENTI_HZ);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam note_rom_t NOTE_ROM = build_note_rom();

endpackage

`default_nettype wire

// ===== design/four_voice_dds_tone_mixer.sv =====
// Four-voice DDS tone mixer top level: phase accumulators, sine lookup,
// mix and millisecond timer. Depends on fvdds_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one item per handshake.
//   kind = load: latches four note tuning words and the event length, clears
//   all phases and the millisecond count; it produces no output item.
//   kind = tick: advances every phase, mixes the four sine samples (sum >> 2,
//   clamped to 255), steps the ms prescaler, and produces one output item
//   (out_valid/out_ready/out_data) carrying the sample and event_done.
//   A tick's result is registered and presented in the cycle after the tick
//   is accepted. The whole per-item step is one register stage (32-bit phase
//   add, sine ROM, small adder tree), so throughput is one item per cycle
//   while the receiver does not stall.
//   The single output register is refilled in the cycle it drains; when the
//   receiver stalls with a result held, in_ready drops until it is taken.
//   Reset clears phases, tuning words, prescaler, counters and the output
//   valid; the tables are constant logic and need no initialization.
`default_nettype none

module four_voice_dds_tone_mixer #(
	parameter int VOICES            = fvdds_pkg::VOICES_DEF,
	parameter int PHASE_INDEX_SHIFT = fvdds_pkg::PHASE_INDEX_SHIFT_DEF,
	parameter int TICKS_PER_MS      = fvdds_pkg::TICKS_PER_MS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire fvdds_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output fvdds_pkg::out_item_t      out_data
);
	import fvdds_pkg::*;

	localparam int SUM_W = $clog2(VOICES * 255 + 1);

	logic [PHASE_W-1:0]    phase_q [VOICES];
	logic [PHASE_W-1:0]    tuning_q [VOICES];
	logic [PRESCALE_W-1:0] prescale_q;
	logic [MS_W-1:0]       elapsed_q;
	logic [MS_W-1:0]       duration_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic [PHASE_W-1:0]    phase_nx [VOICES];
	logic [PHASE_W-1:0]    tuning_ld [VOICES];
	logic [SUM_W-1:0]      mix_sum;
	logic [SUM_W-1:0]      mix_shr;
	logic [SAMPLE_W-1:0]   mix_clamped;
	logic [PRESCALE_W-1:0] prescale_inc;
	logic                  ms_wrap;
	logic [PRESCALE_W-1:0] prescale_nx;
	logic [MS_W-1:0]       elapsed_nx;
	logic                  accept;
	logic                  is_load;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_load   = (in_data.kind == KIND_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	for (genvar v = 0; v < VOICES; v++) begin : g_voice
		if (v == 0) begin : g_na
			assign tuning_ld[v] = NOTE_ROM[in_data.note_a];
		end else if (v == 1) begin : g_nb
			assign tuning_ld[v] = NOTE_ROM[in_data.note_b];
		end else if (v == 2) begin : g_nc
			assign tuning_ld[v] = NOTE_ROM[in_data.note_c];
		end else if (v == 3) begin : g_nd
			assign tuning_ld[v] = NOTE_ROM[in_data.note_d];
		end else begin : g_silent
			assign tuning_ld[v] = '0;
		end
		assign phase_nx[v] = phase_q[v] + tuning_q[v];
	end

	always_comb begin
		logic [SAMPLE_W-1:0] idx;
		mix_sum = '0;
		for (int v = 0; v < VOICES; v++) begin
			idx     = SAMPLE_W'(phase_nx[v] >> PHASE_INDEX_SHIFT);
			mix_sum = mix_sum + SUM_W'(SINE_ROM[idx]);
		end
	end

	assign mix_shr     = mix_sum >> MIX_SHIFT;
	assign mix_clamped = (mix_shr > SUM_W'(255)) ? 8'hFF : SAMPLE_W'(mix_shr);

	assign prescale_inc = prescale_q + PRESCALE_W'(1);
	assign ms_wrap      = (prescale_inc >= PRESCALE_W'(TICKS_PER_MS));
	assign prescale_nx  = ms_wrap ? '0 : prescale_inc;
	// elapsed count saturates instead of wrapping
	assign elapsed_nx   = (ms_wrap && (elapsed_q != '1)) ? elapsed_q + MS_W'(1) : elapsed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				phase_q[v]  <= '0;
				tuning_q[v] <= '0;
			end
			prescale_q  <= '0;
			elapsed_q   <= '0;
			duration_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && !is_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				if (is_load) begin
					for (int v = 0; v < VOICES; v++) begin
						phase_q[v]  <= '0;
						tuning_q[v] <= tuning_ld[v];
					end
					duration_q <= in_data.event_ms;
					elapsed_q  <= '0;
				end else begin
					for (int v = 0; v < VOICES; v++)
						phase_q[v] <= phase_nx[v];
					prescale_q  <= prescale_nx;
					elapsed_q   <= elapsed_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_load) begin
			out_data_q.sample     <= mix_clamped;
			out_data_q.event_done <= (elapsed_nx > duration_q);
		end
	end

endmodule

`default_nettype wire

// ===== design/fvdds_checker.sv =====
// Port-level checker for the DDS tone mixer, bound to the top level.
// Depends on fvdds_pkg and four_voice_dds_tone_mixer.
`default_nettype none

module fvdds_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire fvdds_pkg::in_item_t  in_data,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire fvdds_pkg::out_item_t out_data
);
	import fvdds_pkg::*;

	// held result must not change while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output is stalled");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind == KIND_LOAD) |=> !out_valid)
		else $error("load item produced a result");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind == KIND_TICK) |=> out_valid)
		else $error("tick item produced no result");

endmodule

bind four_voice_dds_tone_mixer fvdds_checker u_fvdds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for four_voice_dds_tone_mixer: a clocked driver and
// monitor, a cycle-free predictor with its own sine and tuning-word tables.
// Depends on fvdds_pkg and the four_voice_dds_tone_mixer RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fvdds_pkg::*;

	localparam int N_VOICE        = 4;
	localparam int IDX_SHIFT      = 24;
	localparam int TICKS_MS       = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 120;
	localparam int MAX_SHOWN      = 10;
	localparam int PHASE_ITEMS    = 225;
	localparam logic [63:0] CENTI_CLOCK = 64'd4000000;

	localparam int QW_TAB [65] = '{
		0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
		49, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
		90, 92, 94, 96, 98, 100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
		117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
		127
	};

	// note pitches in centi-hertz, notes 0..7 silent
	localparam int F_TAB [128] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 818, 866, 918, 972,
		1030, 1091, 1156, 1225, 1298, 1375, 1457, 1543,
		1635, 1732, 1835, 1945, 2060, 2183, 2312, 2450,
		2596, 2750, 2914, 3087, 3270, 3465, 3671, 3889,
		4120, 4365, 4625, 4900, 5191, 5500, 5827, 6174,
		6541, 6930, 7342, 7778, 8241, 8731, 9250, 9800,
		10383, 11000, 11654, 12347, 13081, 13859, 14683, 15556,
		16481, 17461, 18500, 19600, 20765, 22000, 23308, 24694,
		26163, 27718, 29366, 31113, 32963, 34923, 36999, 39200,
		41530, 44000, 46616, 49388, 52325, 55437, 58733, 62225,
		65925, 69846, 73999, 78399, 83061, 88000, 93233, 98777,
		104650, 110873, 117466, 124451, 131851, 139691, 147998, 156798,
		166122, 176000, 186466, 197553, 209300, 221746, 234932, 248902,
		263702, 279383, 295996, 313596, 332244, 352000, 372931, 395107,
		418601, 443492, 469864, 497803, 527404, 558765, 591991, 627193,
		664488, 704000, 745862, 790213
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	four_voice_dds_tone_mixer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  sine_tab [256];
	logic [31:0] tune_tab [128];
	logic [31:0] phase_acc [N_VOICE];
	logic [31:0] tune_word [N_VOICE];
	logic [5:0]  ms_prescale;
	logic [15:0] ms_elapsed;
	logic [15:0] ms_limit;

	in_item_t  pending_items [$];
	out_item_t expected_samples [$];
	out_item_t want;

	int idle_pct   = 0;
	int stall_pct  = 0;
	int mismatches = 0;
	int accepted_in = 0;
	int quiet_cycles = 0;
	bit in_took  = 1'b0;
	bit hold_off = 1'b0;

	task automatic build_tables();
		logic [63:0] num;
		int quad;
		int k;
		int mag;
		for (int i = 0; i < 256; i++) begin
			quad = i >> 6;
			k    = i & 63;
			mag  = quad[0] ? QW_TAB[64 - k] : QW_TAB[k];
			sine_tab[i] = 8'(quad[1] ? 128 - mag : 128 + mag);
		end
		for (int i = 0; i < 128; i++) begin
			num = 64'(F_TAB[i]) << 32;
			tune_tab[i] = 32'(num / CENTI_CLOCK);
		end
		for (int v = 0; v < N_VOICE; v++) begin
			phase_acc[v] = '0;
			tune_word[v] = '0;
		end
		ms_prescale = '0;
		ms_elapsed  = '0;
		ms_limit    = '0;
	endtask

	// advance the tone model by one accepted item, queue the sample it yields
	task automatic tone_predict(input in_item_t it);
		logic [6:0]  notes [N_VOICE];
		logic [9:0]  mix;
		out_item_t   res;
		notes = '{it.note_a, it.note_b, it.note_c, it.note_d};
		if (it.kind == KIND_LOAD) begin
			for (int v = 0; v < N_VOICE; v++) begin
				tune_word[v] = tune_tab[notes[v]];
				phase_acc[v] = '0;
			end
			ms_limit   = it.event_ms;
			ms_elapsed = '0;
		end else begin
			mix = '0;
			for (int v = 0; v < N_VOICE; v++) begin
				phase_acc[v] = phase_acc[v] + tune_word[v];
				mix = mix + sine_tab[8'(phase_acc[v] >> IDX_SHIFT)];
			end
			mix = mix >> MIX_SHIFT;
			res.sample = (mix > 10'd255) ? 8'd255 : mix[7:0];
			ms_prescale = ms_prescale + 6'd1;
			if (ms_prescale >= TICKS_MS) begin
				ms_prescale = '0;
				if (ms_elapsed != 16'hFFFF)
					ms_elapsed = ms_elapsed + 16'd1;
			end
			res.event_done = (ms_elapsed > ms_limit);
			expected_samples.push_back(res);
		end
	endtask

	task automatic report_mismatch(input string what, input out_item_t exp_item,
			input out_item_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%s: got sample %0d done %0b, expected sample %0d done %0b",
				what, got.sample, got.event_done, exp_item.sample, exp_item.event_done);
	endtask

	function automatic in_item_t make_item(input logic kind, input int a, input int b,
			input int c, input int d, input int ms);
		in_item_t it;
		it.kind     = kind;
		it.note_a   = 7'(a);
		it.note_b   = 7'(b);
		it.note_c   = 7'(c);
		it.note_d   = 7'(d);
		it.event_ms = 16'(ms);
		return it;
	endfunction

	function automatic in_item_t rand_item(input logic kind);
		int ms;
		// short events so the done flag shows up within a sequence
		ms = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(3);
		return make_item(kind, $urandom_range(127), $urandom_range(127),
			$urandom_range(127), $urandom_range(127), ms);
	endfunction

	task automatic push_random(input int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 80) begin
				pending_items.push_back(rand_item(KIND_LOAD));
				len = $urandom_range(120, 10);
				// keep the phase at its item count
				if (len >= left)
					len = left - 1;
				repeat (len) pending_items.push_back(rand_item(KIND_TICK));
				left -= len + 1;
			end else begin
				len = $urandom_range(10, 1);
				if (len > left)
					len = left;
				repeat (len) pending_items.push_back(rand_item(1'($urandom_range(1))));
				left -= len;
			end
		end
	endtask

	task automatic push_directed();
		// reset state: silent voices sit at mid-scale
		pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(KIND_TICK, 127, 127, 127, 127, 65535));
		pending_items.push_back(make_item(KIND_LOAD, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
		// top note on every voice, event that never ends
		pending_items.push_back(make_item(KIND_LOAD, 127, 127, 127, 127, 65535));
		repeat (3) pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(KIND_LOAD, 8, 9, 7, 127, 1));
		repeat (2) pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
		// back-to-back loads, the second wins
		pending_items.push_back(make_item(KIND_LOAD, 64, 100, 1, 120, 0));
		pending_items.push_back(make_item(KIND_LOAD, 69, 69, 69, 69, 2));
		repeat (3) pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(KIND_TICK, 127, 127, 127, 127, 65535));
		pending_items.push_back(make_item(KIND_LOAD, 127, 0, 127, 0, 65535));
		repeat (2) pending_items.push_back(make_item(KIND_TICK, 0, 0, 0, 0, 0));
	endtask

	task automatic run_phase(input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		push_random(PHASE_ITEMS);
		while (pending_items.size() != 0)
			@(posedge clk);
	endtask

	// monitor: check results, then feed the predictor with accepted items
	always @(posedge clk) begin
		in_took = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("unexpected item", '0, out_data);
				end else begin
					want = expected_samples.pop_front();
					if (want.sample != out_data.sample || want.event_done != out_data.event_done)
						report_mismatch("mismatch", want, out_data);
				end
			end
			if (in_valid && in_ready) begin
				in_took = 1'b1;
				accepted_in++;
				tone_predict(in_data);
			end
		end
	end

	// driver and receiver, both on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_data  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off so the output register fills and in_ready drops
	initial begin
		wait (accepted_in >= 100);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		build_tables();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_directed();
		run_phase(0, 0);
		run_phase(59, 0);
		run_phase(0, 59);
		run_phase(35, 35);

		while (in_valid)
			@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_samples.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
